FILE: hw/rtl/usb_control_transfer_sequencer_assert.svh
// Assertion macros for the endpoint 0 control transfer sequencer.
`ifndef USB_CONTROL_TRANSFER_SEQUENCER_ASSERT_SVH
`define USB_CONTROL_TRANSFER_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define USB_CTL_ASSERT_IMPLY(label, clock, rstn, cond, prop) \
    label: assert property (@(posedge clock) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("usb control sequencer check failed");
// Next-cycle implication, checked out of reset.
`define USB_CTL_ASSERT_NEXT(label, clock, rstn, cond, prop) \
    label: assert property (@(posedge clock) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("usb control sequencer check failed");
`else
`define USB_CTL_ASSERT_IMPLY(label, clock, rstn, cond, prop)
`define USB_CTL_ASSERT_NEXT(label, clock, rstn, cond, prop)
`endif
`endif

FILE: hw/rtl/usb_ctl_pkg.sv
// Types and constants shared by the control transfer sequencer files.
package usb_ctl_pkg;

    localparam int LEN_W  = 16;
    localparam int DONE_W = 10;
    localparam int MPS_W  = 7;

    localparam logic [1:0] CMD_DATA_REPLY   = 2'd0;
    localparam logic [1:0] CMD_STATUS_REPLY = 2'd1;
    localparam logic [1:0] CMD_XFER_DONE    = 2'd2;
    localparam logic [1:0] CMD_UNUSED       = 2'd3;

    localparam logic [1:0] STAGE_NONE = 2'd0;
    localparam logic [1:0] STAGE_ACK  = 2'd1;
    localparam logic [1:0] STAGE_DATA = 2'd2;

    localparam logic [MPS_W-1:0] MPS_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]        cmd;
        logic              dir_in;
        logic [LEN_W-1:0]  requested_length;
        logic [LEN_W-1:0]  available_length;
        logic              buffer_present;
        logic              endpoint_in;
        logic [DONE_W-1:0] done_length;
        logic              handler_ok;
    } in_item_t;

    typedef struct packed {
        logic              start_xfer;
        logic              xfer_dir_in;
        logic [MPS_W-1:0]  xfer_length;
        logic [LEN_W-1:0]  xfer_offset;
        logic              stall_both;
        logic [1:0]        stage_call;
        logic              accepted;
    } out_item_t;

    // Handshake between the input register and the result register.
    typedef struct packed {
        logic item_valid;
        logic result_free;
    } stage_ctl_t;

endpackage

FILE: hw/rtl/usb_ctl_in_if.sv
// Valid/ready channel carrying sequencer events.
interface usb_ctl_in_if;
    logic                 valid;
    logic                 ready;
    usb_ctl_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/usb_ctl_out_if.sv
// Valid/ready channel carrying sequencer results.
interface usb_ctl_out_if;
    logic                  valid;
    logic                  ready;
    usb_ctl_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/usb_ctl_in_stage.sv
// Input register: holds one event until the result register can take it.
module usb_ctl_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    usb_ctl_in_if.sink            request,
    input  logic                  result_free,
    output usb_ctl_pkg::stage_ctl_t ctl,
    output usb_ctl_pkg::in_item_t item
);
    import usb_ctl_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    assign request.ready = !valid_reg || result_free;
    assign take          = request.valid && request.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (result_free)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= request.payload;
        end
    end

    assign ctl.item_valid  = valid_reg;
    assign ctl.result_free = result_free;
    assign item            = item_reg;
endmodule

FILE: hw/rtl/usb_ctl_core.sv
// Transfer state, packet size register and the per-event step logic.
module usb_ctl_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  usb_ctl_pkg::stage_ctl_t         ctl,
    input  usb_ctl_pkg::in_item_t           item,
    input  logic                            cfg_we,
    input  logic [usb_ctl_pkg::MPS_W-1:0]   cfg_wdata,
    output logic                            fire,
    output usb_ctl_pkg::out_item_t          result_item
);
    import usb_ctl_pkg::*;

    logic [MPS_W-1:0] max_packet_size_reg;
    logic             dir_in_reg,   dir_in_next;
    logic [LEN_W-1:0] req_len_reg,  req_len_next;
    logic [LEN_W-1:0] xfer_len_reg, xfer_len_next;
    logic [LEN_W-1:0] bytes_reg,    bytes_next;
    logic             buf_reg,      buf_next;

    logic [LEN_W-1:0] min_len;
    logic [LEN_W-1:0] bytes_sum;
    logic [LEN_W-1:0] rem_base;
    logic [LEN_W-1:0] rem_len;
    logic [LEN_W-1:0] mps_ext;
    logic [LEN_W-1:0] done_ext;
    logic [MPS_W-1:0] pkt_len;

    assign fire     = ctl.item_valid && ctl.result_free;
    assign mps_ext  = {{(LEN_W-MPS_W){1'b0}}, max_packet_size_reg};
    assign done_ext = {{(LEN_W-DONE_W){1'b0}}, item.done_length};
    assign min_len  = (item.available_length < item.requested_length)
                      ? item.available_length : item.requested_length;
    assign bytes_sum = bytes_reg + done_ext;

    // Remaining length of the data packet: fresh request starts at offset zero.
    always_comb
    begin
        if (item.cmd == CMD_DATA_REPLY)
        begin
            rem_base = min_len;
        end
        else
        begin
            rem_base = (bytes_sum < xfer_len_reg) ? (xfer_len_reg - bytes_sum) : '0;
        end
        rem_len = rem_base;
        pkt_len = (rem_len < mps_ext) ? rem_len[MPS_W-1:0] : max_packet_size_reg;
    end

    always_comb
    begin
        dir_in_next   = dir_in_reg;
        req_len_next  = req_len_reg;
        xfer_len_next = xfer_len_reg;
        bytes_next    = bytes_reg;
        buf_next      = buf_reg;
        result_item   = '0;

        case (item.cmd)
            CMD_DATA_REPLY:
            begin
                dir_in_next   = item.dir_in;
                req_len_next  = item.requested_length;
                xfer_len_next = min_len;
                bytes_next    = '0;
                buf_next      = item.buffer_present;
                if (item.requested_length != '0)
                begin
                    // No buffer behind a nonzero transfer: latch only, start nothing.
                    if (!(min_len != '0 && !item.buffer_present))
                    begin
                        result_item.start_xfer  = 1'b1;
                        result_item.xfer_dir_in = item.dir_in;
                        result_item.xfer_length = pkt_len;
                        result_item.accepted    = 1'b1;
                    end
                end
                else
                begin
                    result_item.start_xfer  = 1'b1;
                    result_item.xfer_dir_in = !item.dir_in;
                    result_item.accepted    = 1'b1;
                end
            end
            CMD_STATUS_REPLY:
            begin
                dir_in_next             = item.dir_in;
                req_len_next            = '0;
                xfer_len_next           = '0;
                bytes_next              = '0;
                buf_next                = 1'b0;
                result_item.start_xfer  = 1'b1;
                result_item.xfer_dir_in = !item.dir_in;
                result_item.accepted    = 1'b1;
            end
            CMD_XFER_DONE:
            begin
                if (item.endpoint_in != dir_in_reg)
                begin
                    // Status stage completed.
                    if (item.done_length != '0)
                    begin
                        result_item.stage_call = STAGE_ACK;
                        result_item.accepted   = item.handler_ok;
                    end
                end
                else if (!dir_in_reg && (!buf_reg || done_ext > mps_ext))
                begin
                    // Drop OUT data with nowhere to go or longer than one packet.
                end
                else
                begin
                    bytes_next = bytes_sum;
                    if (bytes_sum == req_len_reg || done_ext < mps_ext)
                    begin
                        result_item.stage_call = STAGE_DATA;
                        result_item.accepted   = 1'b1;
                        if (item.handler_ok)
                        begin
                            result_item.start_xfer  = 1'b1;
                            result_item.xfer_dir_in = !dir_in_reg;
                        end
                        else
                        begin
                            result_item.stall_both = 1'b1;
                        end
                    end
                    else
                    begin
                        result_item.start_xfer  = 1'b1;
                        result_item.xfer_dir_in = dir_in_reg;
                        result_item.xfer_length = pkt_len;
                        result_item.xfer_offset = bytes_sum;
                        result_item.accepted    = 1'b1;
                    end
                end
            end
            default:
            begin
                result_item = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_packet_size_reg <= MPS_RESET;
            dir_in_reg          <= 1'b0;
            req_len_reg         <= '0;
            xfer_len_reg        <= '0;
            bytes_reg           <= '0;
            buf_reg             <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_packet_size_reg <= cfg_wdata;
            end
            if (fire)
            begin
                dir_in_reg   <= dir_in_next;
                req_len_reg  <= req_len_next;
                xfer_len_reg <= xfer_len_next;
                bytes_reg    <= bytes_next;
                buf_reg      <= buf_next;
            end
        end
    end
endmodule

FILE: hw/rtl/usb_ctl_out_stage.sv
// Result register: holds one result until the consumer takes it.
module usb_ctl_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  usb_ctl_pkg::out_item_t result_item,
    usb_ctl_out_if.source          result,
    output logic                   result_free
);
    import usb_ctl_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign result_free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= result_item;
        end
    end

    assign result.valid   = valid_reg;
    assign result.payload = item_reg;
endmodule

FILE: hw/rtl/usb_control_transfer_sequencer.sv
// Top level of the USB endpoint 0 control transfer sequencer.
`include "usb_control_transfer_sequencer_assert.svh"

// Sequences the data and status stages of a device control transfer on
// endpoint 0. Each event on the request channel (data reply, status-only
// reply, or endpoint transfer completion) yields exactly one transfer on the
// result channel, telling the caller whether to start a packet, its
// direction, length and buffer offset, whether to stall both directions,
// and which handler stage was consulted. One event is taken every clock
// while the result channel is not stalled. An accepted event is held in the
// input register; its result is then loaded into the result register and
// offered on the result channel. The step logic between the registers reads
// and updates the transfer state in the same cycle, so consecutive events
// chain without bubbles. Backpressure on the result channel holds both
// registers; the request channel keeps accepting as long as the input
// register is empty or the result register is free or being drained. Write
// max_packet_size through cfg_we/cfg_wdata only while no events are in
// flight; it resets to 64 bytes.
module usb_control_transfer_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [usb_ctl_pkg::MPS_W-1:0] cfg_wdata,
    usb_ctl_in_if.sink                    request,
    usb_ctl_out_if.source                 result
);
    import usb_ctl_pkg::*;

    stage_ctl_t ctl;
    in_item_t   item;
    out_item_t  result_item;
    logic       result_free;
    logic       fire;
    logic       stall_shown;
    logic       stall_shape_ok;

    // Hold the event until the result register has room.
    usb_ctl_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request),
        .result_free (result_free),
        .ctl         (ctl),
        .item        (item)
    );

    // Advance the transfer state and form the result.
    usb_ctl_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .item        (item),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fire        (fire),
        .result_item (result_item)
    );

    // Register the result for the consumer.
    usb_ctl_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (fire),
        .result_item (result_item),
        .result      (result),
        .result_free (result_free)
    );

    assign stall_shown    = result.valid && result.payload.stall_both;
    assign stall_shape_ok = (result.payload.stage_call == STAGE_DATA)
                            && result.payload.accepted && !result.payload.start_xfer;

    // An event leaving the input register lands in the result register.
    `USB_CTL_ASSERT_NEXT(a_fire_loads_result, clk, rst_n, fire, result.valid)

    // A stall only comes out of a rejected data stage, which is still a success.
    `USB_CTL_ASSERT_IMPLY(a_stall_is_data_stage, clk, rst_n, stall_shown, stall_shape_ok)

    // The unused command produces an empty result.
    `USB_CTL_ASSERT_NEXT(a_unused_cmd_empty, clk, rst_n, fire && item.cmd == CMD_UNUSED, result.payload == '0)
endmodule
